FILE: design/stl_pkg.sv
// Shared types and constants for the script token lexer.
// No dependencies; used by every module of the block.
package stl_pkg;

  localparam int unsigned LINE_BITS_DEF = 24;
  localparam int unsigned LINE_OUT_BITS = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;

  typedef enum logic [2:0] {
    CLS_IDENT   = 3'd0,
    CLS_NUMBER  = 3'd1,
    CLS_STRING  = 3'd2,
    CLS_PUNCT   = 3'd3,
    CLS_UNKNOWN = 3'd4,
    CLS_END     = 3'd5
  } cls_t;

  typedef struct packed {
    cls_t                     cls;
    logic [7:0]               tok_byte;
    logic                     has_byte;
    logic                     done;
    logic [LINE_OUT_BITS-1:0] line;
    logic                     last;
  } item_t;

endpackage

FILE: design/script_token_lexer_unit.sv
// Script token lexer, top level: joins the lexer state machine and the
// result queue. Depends on stl_pkg, stl_lexer and stl_queue.
//
// One source byte is taken per cycle while in_ready is high, and classified in
// the same cycle; its zero, one or two result items go into a four-entry queue
// that feeds the output port; in_ready is high while it holds at most two items.
// With out_ready held high the queue gives one item per clock, so the input
// side runs at one item per clock except where bytes that give two results
// outnumber bytes that give none; each extra item held up that way stalls
// the input. The queue is the only stage between the ports, so a byte's first
// result can appear at the earliest in the cycle after the byte is taken.
// Reset puts the lexer in its start state with the line counter at one.
module script_token_lexer_unit #(
  parameter int unsigned LINE_BITS = stl_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_class,
  output logic [7:0]  out_token_byte,
  output logic        out_has_byte,
  output logic        out_token_done,
  output logic [23:0] out_line_number,
  output logic        out_last_of_run
);

  logic           step, room;
  logic [1:0]     lex_cnt, wr_cnt;
  stl_pkg::item_t item0, item1, rd_item;

  assign in_ready = room;
  assign step     = in_valid && room;
  assign wr_cnt   = step ? lex_cnt : 2'd0;

  stl_lexer #(.LINE_BITS(LINE_BITS)) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .wr_cnt       (lex_cnt),
    .item0        (item0),
    .item1        (item1)
  );

  stl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_item0 (item0),
    .wr_item1 (item1),
    .room     (room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_item  (rd_item)
  );

  assign out_token_class = rd_item.cls;
  assign out_token_byte  = rd_item.tok_byte;
  assign out_has_byte    = rd_item.has_byte;
  assign out_token_done  = rd_item.done;
  assign out_line_number = rd_item.line;
  assign out_last_of_run = rd_item.last;

endmodule

FILE: design/stl_lexer.sv
// Lexer state machine: classifies one byte per accepted item, holds mode,
// escape flag and line counter, and forms up to two result items.
// Depends on stl_pkg.
module stl_lexer #(
  parameter int unsigned LINE_BITS = stl_pkg::LINE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          end_of_input,
  output logic [1:0]    wr_cnt,
  output stl_pkg::item_t item0,
  output stl_pkg::item_t item1
);

  typedef enum logic [3:0] {
    M_START      = 4'd0,
    M_IDENT      = 4'd1,
    M_NUMBER     = 4'd2,
    M_STR_SQ     = 4'd3,
    M_STR_DQ     = 4'd4,
    M_SLASH      = 4'd5,
    M_BLOCK      = 4'd6,
    M_BLOCK_STAR = 4'd7,
    M_LINE       = 4'd8
  } mode_t;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [7:0] CH_SPACE_L = stl_pkg::CH_SPACE;

  mode_t                mode_r, mode_nxt;
  logic                 esc_r, esc_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic [LINE_BITS+stl_pkg::LINE_OUT_BITS-1:0] line_ext;
  logic [stl_pkg::LINE_OUT_BITS-1:0]           line_out;

  logic is_letter, is_digit, is_punct, is_blank, id_cont, num_cont;

  logic           st_emit, st_bump, bump;
  mode_t          st_mode;
  stl_pkg::item_t st_item;
  logic           a_emit, b_emit;
  stl_pkg::item_t a_item, b_item;
  logic [7:0]     quote;

  function automatic stl_pkg::item_t mk(stl_pkg::cls_t c, logic [7:0] b, logic has,
                                        logic dn, logic [stl_pkg::LINE_OUT_BITS-1:0] ln);
    stl_pkg::item_t it;
    it.cls      = c;
    it.tok_byte = has ? b : 8'd0;
    it.has_byte = has;
    it.done     = dn;
    it.line     = ln;
    it.last     = 1'b0;
    return it;
  endfunction

  assign line_ext = {{stl_pkg::LINE_OUT_BITS{1'b0}}, line_r};
  assign line_out = line_ext[stl_pkg::LINE_OUT_BITS-1:0];

  always_comb begin
    is_letter = ((data_byte | 8'h20) >= 8'h61) && ((data_byte | 8'h20) <= 8'h7A);
    is_digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    is_blank  = (data_byte == CH_SPACE_L) || (data_byte == stl_pkg::CH_CR) ||
                (data_byte == stl_pkg::CH_TAB);
    is_punct  = (data_byte == 8'h7B) || (data_byte == 8'h7D) || (data_byte == 8'h26) ||
                (data_byte == 8'h7C) || (data_byte == stl_pkg::CH_STAR) ||
                (data_byte == 8'h3B) || (data_byte == 8'h3D) || (data_byte == 8'h28) ||
                (data_byte == 8'h29) || (data_byte == 8'h2C) || (data_byte == 8'h5B) ||
                (data_byte == 8'h5D);
    id_cont   = is_letter || is_digit || (data_byte == stl_pkg::CH_UNDERSCORE);
    num_cont  = is_digit || (data_byte == stl_pkg::CH_PLUS) ||
                (data_byte == stl_pkg::CH_MINUS);
  end

  // start-state handling of the current byte
  always_comb begin
    st_emit = 1'b0;
    st_bump = 1'b0;
    st_mode = M_START;
    st_item = mk(stl_pkg::CLS_UNKNOWN, data_byte, 1'b1, 1'b1, line_out);
    priority if (is_blank) begin
    end else if (data_byte == stl_pkg::CH_LF) begin
      st_bump = 1'b1;
    end else if (is_punct) begin
      st_emit = 1'b1;
      st_item = mk(stl_pkg::CLS_PUNCT, data_byte, 1'b1, 1'b1, line_out);
    end else if (data_byte == stl_pkg::CH_SLASH) begin
      st_mode = M_SLASH;
    end else if (is_letter || data_byte == stl_pkg::CH_UNDERSCORE) begin
      st_emit = 1'b1;
      st_item = mk(stl_pkg::CLS_IDENT, data_byte, 1'b1, 1'b0, line_out);
      st_mode = M_IDENT;
    end else if (num_cont) begin
      st_emit = 1'b1;
      st_item = mk(stl_pkg::CLS_NUMBER, data_byte, 1'b1, 1'b0, line_out);
      st_mode = M_NUMBER;
    end else if (data_byte == stl_pkg::CH_SQUOTE) begin
      st_mode = M_STR_SQ;
    end else if (data_byte == stl_pkg::CH_DQUOTE) begin
      st_mode = M_STR_DQ;
    end else begin
      st_emit = 1'b1;
    end
  end

  always_comb begin
    quote    = (mode_r == M_STR_SQ) ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE;
    a_emit   = 1'b0;
    a_item   = mk(stl_pkg::CLS_END, 8'd0, 1'b0, 1'b1, line_out);
    b_emit   = 1'b0;
    b_item   = st_item;
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    bump     = 1'b0;
    if (end_of_input) begin
      b_emit   = 1'b1;
      b_item   = mk(stl_pkg::CLS_END, 8'd0, 1'b0, 1'b1, line_out);
      mode_nxt = M_START;
      esc_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          if (id_cont) begin
            b_emit = 1'b1;
            b_item = mk(stl_pkg::CLS_IDENT, data_byte, 1'b1, 1'b0, line_out);
          end else begin
            a_emit   = 1'b1;
            a_item   = mk(stl_pkg::CLS_IDENT, 8'd0, 1'b0, 1'b1, line_out);
            b_emit   = st_emit;
            mode_nxt = st_mode;
            bump     = st_bump;
          end
        end
        M_NUMBER: begin
          if (num_cont) begin
            b_emit = 1'b1;
            b_item = mk(stl_pkg::CLS_NUMBER, data_byte, 1'b1, 1'b0, line_out);
          end else begin
            a_emit   = 1'b1;
            a_item   = mk(stl_pkg::CLS_NUMBER, 8'd0, 1'b0, 1'b1, line_out);
            b_emit   = st_emit;
            mode_nxt = st_mode;
            bump     = st_bump;
          end
        end
        M_STR_SQ, M_STR_DQ: begin
          b_item = mk(stl_pkg::CLS_STRING, data_byte, 1'b1, 1'b0, line_out);
          priority if (esc_r) begin
            esc_nxt = 1'b0;
            b_emit  = 1'b1;
          end else if (data_byte == quote) begin
            b_emit   = 1'b1;
            b_item   = mk(stl_pkg::CLS_STRING, 8'd0, 1'b0, 1'b1, line_out);
            mode_nxt = M_START;
          end else if (data_byte == stl_pkg::CH_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else begin
            b_emit = 1'b1;
          end
        end
        M_SLASH: begin
          priority if (data_byte == stl_pkg::CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else if (data_byte == stl_pkg::CH_SLASH) begin
            mode_nxt = M_LINE;
          end else begin
            a_emit   = 1'b1;
            a_item   = mk(stl_pkg::CLS_UNKNOWN, stl_pkg::CH_SLASH, 1'b1, 1'b1, line_out);
            b_emit   = st_emit;
            mode_nxt = st_mode;
            bump     = st_bump;
          end
        end
        M_BLOCK: begin
          if (data_byte == stl_pkg::CH_STAR) begin
            mode_nxt = M_BLOCK_STAR;
          end else if (data_byte == stl_pkg::CH_LF) begin
            bump = 1'b1;
          end
        end
        M_BLOCK_STAR: begin
          if (data_byte == stl_pkg::CH_SLASH) begin
            mode_nxt = M_START;
          end else if (data_byte != stl_pkg::CH_STAR) begin
            mode_nxt = M_BLOCK;
            bump     = (data_byte == stl_pkg::CH_LF);
          end
        end
        M_LINE: begin
          if (data_byte == stl_pkg::CH_LF) begin
            mode_nxt = M_START;
            bump     = 1'b1;
          end
        end
        default: begin
          b_emit   = st_emit;
          mode_nxt = st_mode;
          bump     = st_bump;
        end
      endcase
    end
    line_nxt = (bump && line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  end

  always_comb begin
    wr_cnt = {1'b0, a_emit} + {1'b0, b_emit};
    item0  = a_emit ? a_item : b_item;
    item1  = b_item;
    item0.last = !(a_emit && b_emit);
    item1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      esc_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
    end else if (step) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

FILE: design/stl_queue.sv
// Result queue: takes up to two items per cycle, gives one per cycle while rd_ready is high.
// Depends on stl_pkg.
module stl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     wr_cnt,
  input  stl_pkg::item_t wr_item0,
  input  stl_pkg::item_t wr_item1,
  output logic           room,
  output logic           rd_valid,
  input  logic           rd_ready,
  output stl_pkg::item_t rd_item
);

  localparam int unsigned DEPTH = stl_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  stl_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;

  assign room      = (count_r <= CW'(DEPTH - 2));
  assign rd_valid  = (count_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];
  assign pop       = rd_valid && rd_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(wr_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_item0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= wr_item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/stl_checker.sv
// Port-level checks for the script token lexer, bound to the top level.
// Depends on stl_pkg and script_token_lexer_unit.
module stl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_input,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_token_class,
  input logic [7:0]  out_token_byte,
  input logic        out_has_byte,
  input logic        out_token_done,
  input logic [23:0] out_line_number,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_token_class, out_token_byte, out_has_byte, out_token_done,
               out_line_number, out_last_of_run}))
    else $error("stalled result item changed");

  a_bare_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_token_done)
    else $error("item without byte not marked done");

  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_class == stl_pkg::CLS_END |->
      out_last_of_run && !out_has_byte && out_token_done)
    else $error("end token malformed");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_input |=> out_valid)
    else $error("end of input gave no result");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_end_of_input (in_end_of_input),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_class (out_token_class),
  .out_token_byte  (out_token_byte),
  .out_has_byte    (out_has_byte),
  .out_token_done  (out_token_done),
  .out_line_number (out_line_number),
  .out_last_of_run (out_last_of_run)
);

FILE: bench/script_token_lexer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for script_token_lexer_unit: directed and random script text,
// token items predicted per source byte. Depends on stl_pkg and the lexer RTL only.
module script_token_lexer_unit_tb;

  localparam int ITEM_COUNT    = 1700;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 150;
  localparam int PAUSE_AT      = 1000;
  localparam int CALM_ITEMS    = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IDENT_TAIL = "abcxyzABCXYZ_0123456789";
  localparam string NUM_CHARS  = "0123456789+-";
  localparam string PUNCT_SET  = "{}&|*;=(),[]";
  localparam string BLANK_SET  = " \t\015\n";
  localparam string BLOCK_BODY = "x */\n";
  localparam string LINE_BODY  = "y /*\"'";

  typedef enum logic [3:0] {
    MODE_START, MODE_IDENT, MODE_NUMBER, MODE_STR_SQ, MODE_STR_DQ,
    MODE_SLASH, MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE
  } lex_mode_t;

  class token_scoreboard;
    lex_mode_t      mode;
    bit             escape_on;
    logic [23:0]    line_cnt;
    stl_pkg::item_t tokens_due[$];
    stl_pkg::item_t step_out[$];
    int             errors;

    function new();
      mode = MODE_START;
      escape_on = 1'b0;
      line_cnt = 24'd1;
      errors = 0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit is_letter(logic [7:0] b);
      return (b | 8'h20) >= "a" && (b | 8'h20) <= "z";
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_punct(logic [7:0] b);
      case (b)
        "{", "}", "&", "|", stl_pkg::CH_STAR, ";", "=", "(", ")", ",", "[", "]":
          return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void emit(stl_pkg::cls_t c, logic [7:0] b, bit has, bit done);
      stl_pkg::item_t it;
      it.cls = c;
      it.tok_byte = has ? b : 8'h00;
      it.has_byte = has;
      it.done = done;
      it.line = line_cnt;
      it.last = 1'b0;
      step_out.push_back(it);
    endfunction

    function void next_line();
      if (line_cnt != {24{1'b1}}) line_cnt = line_cnt + 24'd1;
    endfunction

    function void restart(logic [7:0] b);
      mode = MODE_START;
      if (b == stl_pkg::CH_SPACE || b == stl_pkg::CH_CR || b == stl_pkg::CH_TAB) begin
      end else if (b == stl_pkg::CH_LF) begin
        next_line();
      end else if (is_punct(b)) begin
        emit(stl_pkg::CLS_PUNCT, b, 1'b1, 1'b1);
      end else if (b == stl_pkg::CH_SLASH) begin
        mode = MODE_SLASH;
      end else if (is_letter(b) || b == stl_pkg::CH_UNDERSCORE) begin
        emit(stl_pkg::CLS_IDENT, b, 1'b1, 1'b0);
        mode = MODE_IDENT;
      end else if (b == stl_pkg::CH_PLUS || b == stl_pkg::CH_MINUS || is_digit(b)) begin
        emit(stl_pkg::CLS_NUMBER, b, 1'b1, 1'b0);
        mode = MODE_NUMBER;
      end else if (b == stl_pkg::CH_SQUOTE) begin
        escape_on = 1'b0;
        mode = MODE_STR_SQ;
      end else if (b == stl_pkg::CH_DQUOTE) begin
        escape_on = 1'b0;
        mode = MODE_STR_DQ;
      end else begin
        emit(stl_pkg::CLS_UNKNOWN, b, 1'b1, 1'b1);
      end
    endfunction

    function void lex_source_item(logic [7:0] b, bit at_end);
      logic [7:0]     quote;
      stl_pkg::item_t it;
      step_out.delete();
      if (at_end) begin
        mode = MODE_START;
        escape_on = 1'b0;
        emit(stl_pkg::CLS_END, 8'h00, 1'b0, 1'b1);
      end else begin
        case (mode)
          MODE_IDENT: begin
            if (is_letter(b) || is_digit(b) || b == stl_pkg::CH_UNDERSCORE) begin
              emit(stl_pkg::CLS_IDENT, b, 1'b1, 1'b0);
            end else begin
              emit(stl_pkg::CLS_IDENT, 8'h00, 1'b0, 1'b1);
              restart(b);
            end
          end
          MODE_NUMBER: begin
            if (is_digit(b) || b == stl_pkg::CH_PLUS || b == stl_pkg::CH_MINUS) begin
              emit(stl_pkg::CLS_NUMBER, b, 1'b1, 1'b0);
            end else begin
              emit(stl_pkg::CLS_NUMBER, 8'h00, 1'b0, 1'b1);
              restart(b);
            end
          end
          MODE_STR_SQ, MODE_STR_DQ: begin
            quote = (mode == MODE_STR_SQ) ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE;
            if (escape_on) begin
              escape_on = 1'b0;
              emit(stl_pkg::CLS_STRING, b, 1'b1, 1'b0);
            end else if (b == quote) begin
              emit(stl_pkg::CLS_STRING, 8'h00, 1'b0, 1'b1);
              mode = MODE_START;
            end else if (b == stl_pkg::CH_BACKSLASH) begin
              escape_on = 1'b1;
            end else begin
              emit(stl_pkg::CLS_STRING, b, 1'b1, 1'b0);
            end
          end
          MODE_SLASH: begin
            if (b == stl_pkg::CH_STAR) begin
              mode = MODE_BLOCK;
            end else if (b == stl_pkg::CH_SLASH) begin
              mode = MODE_LINE;
            end else begin
              emit(stl_pkg::CLS_UNKNOWN, stl_pkg::CH_SLASH, 1'b1, 1'b1);
              restart(b);
            end
          end
          MODE_BLOCK: begin
            if (b == stl_pkg::CH_STAR) mode = MODE_BLOCK_STAR;
            else if (b == stl_pkg::CH_LF) next_line();
          end
          MODE_BLOCK_STAR: begin
            if (b == stl_pkg::CH_SLASH) begin
              mode = MODE_START;
            end else if (b != stl_pkg::CH_STAR) begin
              mode = MODE_BLOCK;
              if (b == stl_pkg::CH_LF) next_line();
            end
          end
          MODE_LINE: begin
            if (b == stl_pkg::CH_LF) begin
              mode = MODE_START;
              next_line();
            end
          end
          default: restart(b);
        endcase
      end
      for (int k = 0; k < step_out.size(); k++) begin
        it = step_out[k];
        it.last = (k == step_out.size() - 1);
        tokens_due.push_back(it);
      end
    endfunction

    function void cmp(string field, logic [23:0] want, logic [23:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_token_item(stl_pkg::item_t seen);
      stl_pkg::item_t want;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected token item, expected none, actual class %0d byte %0h",
                 $time, seen.cls, seen.tok_byte);
      end else begin
        want = tokens_due.pop_front();
        cmp("token_class", 24'(want.cls), 24'(seen.cls));
        cmp("token_byte", 24'(want.tok_byte), 24'(seen.tok_byte));
        cmp("has_byte", 24'(want.has_byte), 24'(seen.has_byte));
        cmp("token_done", 24'(want.done), 24'(seen.done));
        cmp("line_number", want.line, seen.line);
        cmp("last_of_run", 24'(want.last), 24'(seen.last));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_token_class;
  logic [7:0]  out_token_byte;
  logic        out_has_byte;
  logic        out_token_done;
  logic [23:0] out_line_number;
  logic        out_last_of_run;

  token_scoreboard sb;
  logic [8:0]      source_q[$];
  stl_pkg::item_t  seen_item;
  bit              calm;
  bit              hold_done;
  int              accepted;
  int              cycles;

  script_token_lexer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_class (out_token_class),
    .out_token_byte  (out_token_byte),
    .out_has_byte    (out_has_byte),
    .out_token_done  (out_token_done),
    .out_line_number (out_line_number),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function void put_byte(logic [7:0] b);
    source_q.push_back({1'b0, b});
  endfunction

  function void put_text(string s);
    for (int k = 0; k < s.len(); k++) put_byte(s[k]);
  endfunction

  function void put_end();
    source_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] rand_from(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic send_source();
    for (int i = 0; i < source_q.size(); i++) begin
      if (i == PAUSE_AT) begin
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if (i >= source_q.size() - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      in_valid = 1'b1;
      in_data_byte = source_q[i][7:0];
      in_end_of_input = source_q[i][8];
      do @(posedge clk); while (!in_ready);
      sb.lex_source_item(source_q[i][7:0], source_q[i][8]);
      accepted++;
      @(negedge clk);
    end
    in_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_item = {out_token_class, out_token_byte, out_has_byte, out_token_done,
                   out_line_number, out_last_of_run};
      sb.check_token_item(seen_item);
    end
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (calm) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else if (!hold_done && accepted >= HOLD_AT) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  initial begin
    int         kind;
    int         directed_len;
    logic [7:0] quote;
    logic [7:0] c;
    sb = new();
    calm = 1'b0;
    hold_done = 1'b0;
    accepted = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_input = 1'b0;

    put_text("_Zz9(-9+\"a\\\"\n\"");
    put_text("/x/**\n*/");
    put_text("//\n");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(stl_pkg::CH_SQUOTE);
    put_end();
    directed_len = source_q.size();

    while (source_q.size() < directed_len + ITEM_COUNT) begin
      kind = $urandom_range(0, 99);
      if (kind < 18) begin
        put_byte(rand_from(IDENT_HEAD));
        repeat ($urandom_range(0, 6)) put_byte(rand_from(IDENT_TAIL));
      end else if (kind < 30) begin
        repeat ($urandom_range(1, 6)) put_byte(rand_from(NUM_CHARS));
      end else if (kind < 44) begin
        quote = $urandom_range(0, 1) ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE;
        put_byte(quote);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 9))
            0: begin
              put_byte(stl_pkg::CH_BACKSLASH);
              put_byte(c);
            end
            1: put_byte(quote == stl_pkg::CH_SQUOTE ? stl_pkg::CH_DQUOTE : stl_pkg::CH_SQUOTE);
            default: put_byte((c == quote || c == stl_pkg::CH_BACKSLASH) ? "s" : c);
          endcase
        end
        if ($urandom_range(0, 9) != 0) put_byte(quote);
      end else if (kind < 58) begin
        put_byte(rand_from(PUNCT_SET));
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 3)) put_byte(rand_from(BLANK_SET));
      end else if (kind < 77) begin
        put_text("/*");
        repeat ($urandom_range(0, 6)) put_byte(rand_from(BLOCK_BODY));
        put_text("*/");
      end else if (kind < 83) begin
        put_text("//");
        repeat ($urandom_range(0, 5)) put_byte(rand_from(LINE_BODY));
        put_byte(stl_pkg::CH_LF);
      end else if (kind < 87) begin
        put_byte(stl_pkg::CH_SLASH);
      end else if (kind < 97) begin
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_end();
      end
    end

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    send_source();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
